// ===== hw/rtl/srm_pkg.sv =====
// package for the spi register access master
// types, field widths and codes shared by all files of the block
`timescale 1ns / 1ps
`default_nettype none

package srm_pkg;

  localparam int KIND_W = 2;
  localparam int ADDR_W = 6;
  localparam int DATA_W = 24;
  localparam int HALF_W = 16;

  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [HALF_W-1:0] HALF_RESET = 16'd100;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2,
    PH_TAIL = 2'd3
  } phase_t;

  typedef struct packed {
    logic              sck_level;
    logic              sdi_level;
    logic              enable_level;
    logic              busy_res;
    logic              done_res;
    logic [DATA_W-1:0] read_data;
  } srm_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srm_ifs.sv =====
// channel interfaces of the spi register access master
// depends on srm_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface srm_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [srm_pkg::KIND_W-1:0] kind;
  logic [srm_pkg::ADDR_W-1:0] reg_address;
  logic [srm_pkg::DATA_W-1:0] wr_value;
  logic                      sdo_level;

  modport source (output valid, kind, reg_address, wr_value, sdo_level, input ready);
  modport sink (input valid, kind, reg_address, wr_value, sdo_level, output ready);
endinterface

interface srm_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      sck_level;
  logic                      sdi_level;
  logic                      enable_level;
  logic                      busy_res;
  logic                      done_res;
  logic [srm_pkg::DATA_W-1:0] read_data;

  modport source (output valid, sck_level, sdi_level, enable_level, busy_res, done_res,
                  read_data, input ready);
  modport sink (input valid, sck_level, sdi_level, enable_level, busy_res, done_res,
                read_data, output ready);
endinterface

interface srm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [srm_pkg::HALF_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/spi_register_access_master_unit.sv =====
// top level of the spi register access master
// depends on srm_pkg, srm_ifs, srm_seq and srm_obuf
`timescale 1ns / 1ps
`default_nettype none

// SPI master that runs one register access at a time. Every transfer on cmd is one
// tick of the pin sequencer and yields exactly one transfer on rsp showing the pin
// levels after that tick. kind write or read starts a frame of 1 + ADDR_W + DATA_W
// bits (31), MSB first: read flag, address, data. Each bit is one half period
// with sck low, then one with sck high; a read samples sdo as sck falls on the data
// bits. A closing half period with sck low follows the last bit, then enable drops
// and done_res pulses. Starts that arrive during a frame are ignored. Rate: one cmd
// transfer per clock, set by the single pass of the sequencer logic between its
// state registers and the rsp register; cmd stalls only when the rsp register and
// its skid entry are both full. The half period length, in ticks, is written
// through cfg (reset 100, zero counts as one) and is taken at once.
module spi_register_access_master_unit (
  input wire logic  clk,
  input wire logic  rst,
  srm_cmd_if.sink   cmd,
  srm_rsp_if.source rsp,
  srm_cfg_if.sink   cfg
);
  import srm_pkg::*;

  logic              step;
  logic              can_push;
  logic [HALF_W-1:0] half_period;
  srm_result_t       seq_result;
  srm_result_t       rsp_data;

  // configuration register, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_RESET;
    end else if (cfg.valid) begin
      half_period <= cfg.data;
    end
  end

  // a tick advances the sequencer only when its result has a place to go
  assign cmd.ready = can_push;
  assign step      = cmd.valid && can_push;

  srm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .kind        (cmd.kind),
    .reg_address (cmd.reg_address),
    .wr_value    (cmd.wr_value),
    .sdo_level   (cmd.sdo_level),
    .half_period (half_period),
    .result      (seq_result)
  );

  // rsp register plus skid entry
  srm_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (seq_result),
    .can_push  (can_push),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp_data)
  );

  assign rsp.sck_level    = rsp_data.sck_level;
  assign rsp.sdi_level    = rsp_data.sdi_level;
  assign rsp.enable_level = rsp_data.enable_level;
  assign rsp.busy_res     = rsp_data.busy_res;
  assign rsp.done_res     = rsp_data.done_res;
  assign rsp.read_data    = rsp_data.read_data;

endmodule

`default_nettype wire

// ===== hw/rtl/srm_seq.sv =====
// frame sequencer: phase, bit and tick counters, shift registers
// depends on srm_pkg
`timescale 1ns / 1ps
`default_nettype none

module srm_seq (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic [srm_pkg::KIND_W-1:0] kind,
  input  wire logic [srm_pkg::ADDR_W-1:0] reg_address,
  input  wire logic [srm_pkg::DATA_W-1:0] wr_value,
  input  wire logic                       sdo_level,
  input  wire logic [srm_pkg::HALF_W-1:0] half_period,
  output srm_pkg::srm_result_t            result
);
  import srm_pkg::*;

  localparam int FRAME_BITS = 1 + ADDR_W + DATA_W;
  localparam int IDX_W      = $clog2(FRAME_BITS);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(FRAME_BITS - 1);
  localparam logic [IDX_W-1:0] FIRST_DATA = IDX_W'(1 + ADDR_W);

  phase_t                  phase, phase_next;
  logic [IDX_W-1:0]        bit_index, bit_index_next;
  logic [HALF_W-1:0]       tick_count, tick_count_next;
  logic [FRAME_BITS-1:0]   out_shift, out_shift_next;
  logic [DATA_W-1:0]       in_shift, in_shift_next;
  logic                    is_read, is_read_next;
  logic                    done;
  logic                    rd;
  logic [HALF_W-1:0]       h;

  assign h = (half_period == '0) ? HALF_W'(1) : half_period;

  always_comb begin
    phase_next      = phase;
    bit_index_next  = bit_index;
    tick_count_next = tick_count;
    out_shift_next  = out_shift;
    in_shift_next   = in_shift;
    is_read_next    = is_read;
    done            = 1'b0;
    rd              = (kind == KIND_READ);
    case (phase)
      PH_IDLE: begin
        if (kind inside {KIND_WRITE, KIND_READ}) begin
          is_read_next    = rd;
          out_shift_next  = {rd, reg_address, rd ? {DATA_W{1'b0}} : wr_value};
          if (rd) begin
            in_shift_next = '0;
          end
          bit_index_next  = '0;
          tick_count_next = HALF_W'(1);
          phase_next      = PH_LOW;
        end
      end
      PH_LOW: begin
        if (tick_count >= h) begin
          phase_next      = PH_HIGH;
          tick_count_next = HALF_W'(1);
        end else begin
          tick_count_next = tick_count + HALF_W'(1);
        end
      end
      PH_HIGH: begin
        if (tick_count >= h) begin
          // sample sdo as sck falls, data part of a read only
          if (is_read && bit_index >= FIRST_DATA) begin
            in_shift_next = {in_shift[DATA_W-2:0], sdo_level};
          end
          tick_count_next = HALF_W'(1);
          if (bit_index >= LAST_IDX) begin
            phase_next = PH_TAIL;
          end else begin
            bit_index_next = bit_index + IDX_W'(1);
            out_shift_next = {out_shift[FRAME_BITS-2:0], 1'b0};
            phase_next     = PH_LOW;
          end
        end else begin
          tick_count_next = tick_count + HALF_W'(1);
        end
      end
      PH_TAIL: begin
        if (tick_count >= h) begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          bit_index_next  = '0;
          done            = 1'b1;
        end else begin
          tick_count_next = tick_count + HALF_W'(1);
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    result.sck_level    = (phase_next == PH_HIGH);
    result.sdi_level    = (phase_next == PH_LOW || phase_next == PH_HIGH) &&
                          out_shift_next[FRAME_BITS-1];
    result.enable_level = (phase_next != PH_IDLE);
    result.busy_res     = (phase_next != PH_IDLE);
    result.done_res     = done;
    result.read_data    = in_shift_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_index  <= '0;
      tick_count <= '0;
      out_shift  <= '0;
      in_shift   <= '0;
      is_read    <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      tick_count <= tick_count_next;
      out_shift  <= out_shift_next;
      in_shift   <= in_shift_next;
      is_read    <= is_read_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/srm_obuf.sv =====
// result register with one skid entry
// depends on srm_pkg
`timescale 1ns / 1ps
`default_nettype none

module srm_obuf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire srm_pkg::srm_result_t push_data,
  output logic               can_push,
  output logic               out_valid,
  input  wire logic          out_ready,
  output srm_pkg::srm_result_t out_data
);
  import srm_pkg::*;

  srm_result_t skid;
  logic        skid_valid;
  logic        pop;

  assign pop      = out_valid && out_ready;
  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/srm_checker.sv =====
// port-level checks for the spi register access master
// bound to spi_register_access_master_unit, depends on srm_pkg
`timescale 1ns / 1ps
`default_nettype none

module srm_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       rsp_valid,
  input wire logic                       rsp_ready,
  input wire logic                       sck_level,
  input wire logic                       sdi_level,
  input wire logic                       enable_level,
  input wire logic                       busy_res,
  input wire logic                       done_res,
  input wire logic [srm_pkg::DATA_W-1:0] read_data
);

  // sck only toggles inside a frame
  a_sck_in_frame: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && sck_level |-> enable_level)
    else $error("sck high outside a frame");

  // busy and enable track the same frame
  a_busy_enable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> busy_res == enable_level)
    else $error("busy and enable disagree");

  // done marks the tick the frame has ended
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && done_res |-> !enable_level && !sck_level && !sdi_level)
    else $error("done while frame still active");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) && $stable(done_res)
      && $stable(sck_level) && $stable(sdi_level) && $stable(enable_level))
    else $error("stalled result changed");

endmodule

bind spi_register_access_master_unit srm_checker u_srm_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .sck_level    (rsp.sck_level),
  .sdi_level    (rsp.sdi_level),
  .enable_level (rsp.enable_level),
  .busy_res     (rsp.busy_res),
  .done_res     (rsp.done_res),
  .read_data    (rsp.read_data)
);

`default_nettype wire

// ===== tb/sv/srm_pin_checker.sv =====
// checker for the spi register access master: watches cmd, rsp and cfg transfers
// predicts the pin levels of every tick and compares them; depends on srm_pkg, srm_ifs
`timescale 1ns / 1ps

module srm_pin_checker (
  input  wire logic clk,
  input  wire logic rst,
  srm_cmd_if        cmd_mon,
  srm_rsp_if        rsp_mon,
  srm_cfg_if        cfg_mon,
  output int        fail_count,
  output int        outstanding
);
  import srm_pkg::*;

  localparam int FRAME_W = 1 + ADDR_W + DATA_W;
  localparam int MAX_PRINTS = 40;

  // predicted sequencer state
  logic [HALF_W-1:0]  half_ticks;
  phase_t             seq_phase;
  logic [4:0]         bit_idx;
  logic [HALF_W-1:0]  tick_cnt;
  logic [FRAME_W-1:0] frame_bits;
  logic [DATA_W-1:0]  rd_shift;
  logic               rd_frame;

  srm_result_t        levels_q[$];
  int                 result_idx;

  task automatic report_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_PRINTS) begin
      $display("[%0t] result %0d: %s", $time, result_idx, what);
    end
  endtask

  // one tick of the pin sequencer, returns the lines after the tick
  task automatic step_sequencer(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                                input logic [DATA_W-1:0] wd, input logic so,
                                output srm_result_t lv);
    logic [HALF_W-1:0] h;
    logic              done;
    logic              sdi;
    h    = (half_ticks == '0) ? HALF_W'(1) : half_ticks;
    done = 1'b0;
    sdi  = 1'b0;
    case (seq_phase)
      PH_IDLE: begin
        if (k == KIND_WRITE || k == KIND_READ) begin
          rd_frame   = (k == KIND_READ);
          frame_bits = {rd_frame, a, rd_frame ? {DATA_W{1'b0}} : wd};
          if (rd_frame) rd_shift = '0;
          bit_idx    = '0;
          tick_cnt   = HALF_W'(1);
          seq_phase  = PH_LOW;
        end
      end
      PH_LOW: begin
        if (tick_cnt >= h) begin
          seq_phase = PH_HIGH;
          tick_cnt  = HALF_W'(1);
        end else begin
          tick_cnt++;
        end
      end
      PH_HIGH: begin
        if (tick_cnt >= h) begin
          // sdo is sampled as sck falls, data bits only
          if (rd_frame && int'(bit_idx) >= 1 + ADDR_W) rd_shift = {rd_shift[DATA_W-2:0], so};
          tick_cnt = HALF_W'(1);
          if (int'(bit_idx) >= FRAME_W - 1) begin
            seq_phase = PH_TAIL;
          end else begin
            bit_idx++;
            seq_phase = PH_LOW;
          end
        end else begin
          tick_cnt++;
        end
      end
      default: begin
        if (tick_cnt >= h) begin
          seq_phase = PH_IDLE;
          tick_cnt  = '0;
          bit_idx   = '0;
          done      = 1'b1;
        end else begin
          tick_cnt++;
        end
      end
    endcase
    if (seq_phase == PH_LOW || seq_phase == PH_HIGH) sdi = frame_bits[FRAME_W-1-int'(bit_idx)];
    lv.sck_level    = (seq_phase == PH_HIGH);
    lv.sdi_level    = sdi;
    lv.enable_level = (seq_phase != PH_IDLE);
    lv.busy_res     = (seq_phase != PH_IDLE);
    lv.done_res     = done;
    lv.read_data    = rd_shift;
  endtask

  always @(posedge clk) begin
    srm_result_t pred;
    srm_result_t want;
    srm_result_t got;
    if (rst) begin
      half_ticks = HALF_RESET;
      seq_phase  = PH_IDLE;
      bit_idx    = '0;
      tick_cnt   = '0;
      frame_bits = '0;
      rd_shift   = '0;
      rd_frame   = 1'b0;
      levels_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) half_ticks = cfg_mon.data;
      if (cmd_mon.valid && cmd_mon.ready) begin
        step_sequencer(cmd_mon.kind, cmd_mon.reg_address, cmd_mon.wr_value,
                       cmd_mon.sdo_level, pred);
        levels_q.push_back(pred);
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.sck_level    = rsp_mon.sck_level;
        got.sdi_level    = rsp_mon.sdi_level;
        got.enable_level = rsp_mon.enable_level;
        got.busy_res     = rsp_mon.busy_res;
        got.done_res     = rsp_mon.done_res;
        got.read_data    = rsp_mon.read_data;
        if (levels_q.size() == 0) begin
          report_failure("transfer on rsp with no command waiting");
        end else begin
          want = levels_q.pop_front();
          if (got.sck_level !== want.sck_level)
            report_failure($sformatf("sck_level %b, want %b", got.sck_level, want.sck_level));
          if (got.sdi_level !== want.sdi_level)
            report_failure($sformatf("sdi_level %b, want %b", got.sdi_level, want.sdi_level));
          if (got.enable_level !== want.enable_level)
            report_failure($sformatf("enable_level %b, want %b",
                                     got.enable_level, want.enable_level));
          if (got.busy_res !== want.busy_res)
            report_failure($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
          if (got.done_res !== want.done_res)
            report_failure($sformatf("done_res %b, want %b", got.done_res, want.done_res));
          if (got.read_data !== want.read_data)
            report_failure($sformatf("read_data %h, want %h", got.read_data, want.read_data));
        end
        result_idx++;
      end
    end
    outstanding <= levels_q.size();
  end

endmodule

// ===== tb/sv/spi_register_access_master_unit_tb.sv =====
// testbench top for the spi register access master unit
// drives cmd, cfg and rsp ready; srm_pin_checker predicts and compares
// depends on srm_pkg, srm_ifs, srm_pin_checker and the block itself
`timescale 1ns / 1ps

module spi_register_access_master_unit_tb;
  import srm_pkg::*;

  // kind three has no meaning, the block treats it as a plain tick
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT  = 120000;
  localparam int TAIL_CYCLES  = 8;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 85;
  // at a half period of one tick a frame takes 63 ticks, leave some margin
  localparam int FILL_FAST    = 70;

  logic clk = 1'b0;
  logic rst = 1'b1;

  srm_cmd_if cmd_ch ();
  srm_rsp_if rsp_ch ();
  srm_cfg_if cfg_ch ();

  int fail_count;
  int outstanding;

  spi_register_access_master_unit dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  srm_pin_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cmd_mon     (cmd_ch),
    .rsp_mon     (rsp_ch),
    .cfg_mon     (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit, counted in clocks
  int cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still waiting", cycle_cnt, outstanding);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // stretch flags: when set, that side runs without idling
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;

  int n_items    = 0;
  int n_writes   = 0;
  int n_reads    = 0;
  int n_settings = 0;
  int n_results  = 0;

  // one cmd transfer; a random gap goes in front of it unless tx_steady is set.
  // valid stays high across back-to-back transfers, so it is never dropped
  // and raised in the same time step
  task automatic send_tick(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                           input logic [DATA_W-1:0] d, input logic so);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.kind        <= k;
    cmd_ch.reg_address <= a;
    cmd_ch.wr_value    <= d;
    cmd_ch.sdo_level   <= so;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    n_items++;
    if (k == KIND_WRITE) n_writes++;
    if (k == KIND_READ) n_reads++;
  endtask

  // plain ticks with random sdo, used to let a frame run to its end
  task automatic send_fill(input int n);
    repeat (n) send_tick(KIND_TICK, ADDR_W'($urandom), DATA_W'($urandom), 1'($urandom));
  endtask

  // stop sending and wait until every tick has shown up on rsp; outstanding
  // is registered in the checker, so the value read here is from the last edge
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // new half period, only once the block has nothing in flight; a frame
  // may still be running, the new length applies to it right away
  task automatic write_half_period(input logic [HALF_W-1:0] h);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= h;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  // result side: ready drops for a random stall before each result, except
  // in steady stretches, which are redrawn every 64 results
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (n_results % 64 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      stall = rx_steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      n_results++;
    end
  end

  // stimulus
  initial begin
    int r;
    logic [KIND_W-1:0] k;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.kind        <= KIND_TICK;
    cmd_ch.reg_address <= '0;
    cmd_ch.wr_value    <= '0;
    cmd_ch.sdo_level   <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, still at the reset half period of 100 ticks
    // write with all ones in address and data
    send_tick(KIND_WRITE, 6'h3f, 24'hffffff, 1'b1);
    send_tick(KIND_TICK, 6'h00, 24'h000000, 1'b0);
    send_tick(KIND_UNUSED, 6'h3f, 24'hffffff, 1'b1);
    // starts during a frame are ignored
    send_tick(KIND_READ, 6'h15, 24'h123456, 1'b1);
    send_tick(KIND_WRITE, 6'h2a, 24'h654321, 1'b0);
    send_fill(3);
    // half period lowered mid frame: the current half ends on the next tick
    write_half_period(HALF_W'(1));
    send_fill(FILL_FAST);
    // kind three while idle, then a read of address zero
    send_tick(KIND_UNUSED, 6'h3f, 24'hffffff, 1'b1);
    send_tick(KIND_READ, 6'h00, 24'hffffff, 1'b1);
    send_fill(FILL_FAST);
    // write of all zeros
    send_tick(KIND_WRITE, 6'h00, 24'h000000, 1'b0);
    send_fill(FILL_FAST);
    // a half period of zero counts as one tick
    write_half_period(HALF_W'(0));
    send_tick(KIND_READ, 6'h2a, 24'h000000, 1'b0);
    send_fill(FILL_FAST);
    send_tick(KIND_WRITE, 6'h15, 24'h5a5aa5, 1'b1);
    send_fill(FILL_FAST);
    // largest half period, cut short by a lower one mid frame
    write_half_period(HALF_W'(16'hffff));
    send_tick(KIND_READ, 6'h3f, 24'h000000, 1'b1);
    send_fill(6);
    write_half_period(HALF_W'(3));
    send_fill(3 * FILL_FAST);

    // random part: short half periods, half of the items starts with random content,
    // the rest plain ticks and the meaningless kind; a frame may still be
    // running when the next phase writes a new half period
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_half_period(HALF_W'($urandom_range(1, 4)));
      tx_steady = ($urandom_range(0, 2) == 0);
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 19);
        if (r < 8) k = KIND_TICK;
        else if (r < 13) k = KIND_WRITE;
        else if (r < 18) k = KIND_READ;
        else k = KIND_UNUSED;
        send_tick(k, ADDR_W'($urandom), DATA_W'($urandom), 1'($urandom));
      end
    end
    tx_steady = 1'b0;

    // back to the reset value once more
    write_half_period(HALF_RESET);
    send_tick(KIND_WRITE, ADDR_W'($urandom), DATA_W'($urandom), 1'b0);
    send_fill(4);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d ticks over %0d half period settings (0, 1, 3, 100, 65535 among them)",
             n_items, n_settings);
    $display("issued %0d write and %0d read starts, %0d results checked",
             n_writes, n_reads, n_results);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
